/* rtl/jbce_pkg.sv */
`default_nettype none

package jbce_pkg;

  // Field widths of the item channels
  localparam int SYM_W   = 8;
  localparam int EXTRA_W = 16;
  localparam int COMP_W  = 2;
  localparam int POS_W   = 6;
  localparam int COEF_W  = 16;

  // Size field of a DC symbol saturates at the magnitude width
  localparam int SIZE_W  = 5;

  // Special AC symbols
  localparam logic [SYM_W-1:0] SYM_EOB = 8'h00;
  localparam logic [SYM_W-1:0] SYM_ZRL = 8'hF0;
  localparam int ZRL_RUN = 16;

  // Item kinds
  localparam logic REQ_DC = 1'b0;
  localparam logic REQ_AC = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // latch the accepted item
    logic step;   // emit one coefficient into the output register
  } jbce_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start;      // item on the input produces results
    logic last_step;  // the pending step finishes the item
  } jbce_sts_t;

endpackage

`default_nettype wire

/* rtl/jbce_in_if.sv */
`default_nettype none

interface jbce_in_if;
  import jbce_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [SYM_W-1:0]   symbol;
  logic [EXTRA_W-1:0] extra_bits;
  logic [COMP_W-1:0]  component;
  logic               new_scan;

  modport source (
    output valid, req_type, symbol, extra_bits, component, new_scan,
    input  ready
  );

  modport sink (
    input  valid, req_type, symbol, extra_bits, component, new_scan,
    output ready
  );

endinterface

`default_nettype wire

/* rtl/jbce_out_if.sv */
`default_nettype none

interface jbce_out_if;
  import jbce_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         position;
  logic signed [COEF_W-1:0] coefficient;
  logic [COMP_W-1:0]        comp_out;
  logic                     last;
  logic                     overrun;

  modport source (
    output valid, position, coefficient, comp_out, last, overrun,
    input  ready
  );

  modport sink (
    input  valid, position, coefficient, comp_out, last, overrun,
    output ready
  );

endinterface

`default_nettype wire

/* rtl/jbce_ctrl.sv */
`default_nettype none

module jbce_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  jbce_pkg::jbce_sts_t    sts_i,
  output jbce_pkg::jbce_cmd_t    cmd_o
);
  import jbce_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        slot_free;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  // Advance between taking an item and emitting its coefficients
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.start) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.step && sts_i.last_step) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EMIT: begin
        cmd_o.step = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Hold the output item until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.step) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // An item that produces nothing leaves the block ready
  a_no_result_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !sts_i.start |=> in_ready_o)
    else $error("item without results left controller busy");

  // Never take an item while coefficients are still emitted
  a_no_accept_during_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !in_ready_o)
    else $error("input taken during emission");
`endif

endmodule

`default_nettype wire

/* rtl/jbce_dpath.sv */
`default_nettype none

module jbce_dpath #(
  parameter int BLOCK_SIZE     = 64,
  parameter int NUM_COMPONENTS = 3
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  jbce_pkg::jbce_cmd_t                   cmd_i,
  output jbce_pkg::jbce_sts_t                   sts_o,
  input  wire logic                             req_type_i,
  input  wire logic [jbce_pkg::SYM_W-1:0]       symbol_i,
  input  wire logic [jbce_pkg::EXTRA_W-1:0]     extra_bits_i,
  input  wire logic [jbce_pkg::COMP_W-1:0]      component_i,
  input  wire logic                             new_scan_i,
  output logic [jbce_pkg::POS_W-1:0]            position_o,
  output logic signed [jbce_pkg::COEF_W-1:0]    coefficient_o,
  output logic [jbce_pkg::COMP_W-1:0]           comp_out_o,
  output logic                                  last_o,
  output logic                                  overrun_o
);
  import jbce_pkg::*;

  localparam int PW = $clog2(BLOCK_SIZE + 1);
  localparam int CW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam logic [PW-1:0]     BS       = PW'(BLOCK_SIZE);
  localparam logic [PW-1:0]     LAST_POS = PW'(BLOCK_SIZE - 1);
  localparam logic [COMP_W:0]   NCOMP    = (COMP_W + 1)'(NUM_COMPONENTS);
  localparam logic [COMP_W-1:0] COMP_MAX = COMP_W'(NUM_COMPONENTS - 1);

  // Decode size bits of magnitude into a signed coefficient value
  function automatic logic [COEF_W-1:0] mag_value(input logic [SIZE_W-1:0] s,
                                                  input logic [EXTRA_W-1:0] bits);
    logic [EXTRA_W:0]   full;
    logic [EXTRA_W-1:0] msk;
    logic [EXTRA_W-1:0] m;
    full = ((EXTRA_W + 1)'(1) << s) - (EXTRA_W + 1)'(1);
    msk  = full[EXTRA_W-1:0];
    m    = bits & msk;
    if (|(m & ~(msk >> 1))) return m;
    return m - msk;
  endfunction

  // Block and item state
  logic [PW-1:0]     pos_q, pos_d;
  logic [PW-1:0]     zeros_q, zeros_d;
  logic              has_val_q, has_val_d;
  logic              ov_q, ov_d;
  logic [COMP_W-1:0] comp_q, comp_d;
  logic [COEF_W-1:0] val_q, val_d;
  logic [COEF_W-1:0] pred_q [NUM_COMPONENTS];

  // Output register
  logic [POS_W-1:0]  out_pos_q;
  logic [COEF_W-1:0] out_coef_q;
  logic [COMP_W-1:0] out_comp_q;
  logic              out_last_q;
  logic              out_ov_q;

  logic [COMP_W-1:0] comp_cl;
  logic [SIZE_W-1:0] dc_size;
  logic [COEF_W-1:0] pred_sel;
  logic [COEF_W-1:0] pred_new;
  logic [PW-1:0]     remaining;
  logic [PW-1:0]     ac_zeros;
  logic              ac_has_val;
  logic              ac_ov;
  logic              block_open;
  logic              emit_zero;
  logic [PW-1:0]     pos_inc;

  // Decode the incoming item
  always_comb begin
    comp_cl = ({1'b0, component_i} >= NCOMP) ? COMP_MAX : component_i;
    dc_size = (symbol_i > SYM_W'(ZRL_RUN)) ? SIZE_W'(ZRL_RUN) : symbol_i[SIZE_W-1:0];
    pred_sel = new_scan_i ? '0 : pred_q[comp_cl[CW-1:0]];
    pred_new = pred_sel + mag_value(dc_size, extra_bits_i);

    remaining  = BS - pos_q;
    ac_has_val = 1'b0;
    if (symbol_i == SYM_EOB) begin
      ac_zeros = remaining;
    end else if (symbol_i == SYM_ZRL) begin
      ac_zeros = PW'(ZRL_RUN);
    end else begin
      ac_zeros   = PW'(symbol_i[7:4]);
      ac_has_val = 1'b1;
    end
    ac_ov = ({1'b0, ac_zeros} + (PW + 1)'(ac_has_val)) > {1'b0, remaining};
    block_open = (pos_q != '0);
  end

  assign sts_o.start = (req_type_i == REQ_DC) || block_open;

  // Emit zeros first, then the value
  assign emit_zero       = (zeros_q != '0);
  assign pos_inc         = pos_q + PW'(1);
  assign sts_o.last_step = (pos_q == LAST_POS) ||
                           !emit_zero || ((zeros_q == PW'(1)) && !has_val_q);

  // Load an item or advance one position
  always_comb begin
    pos_d     = pos_q;
    zeros_d   = zeros_q;
    has_val_d = has_val_q;
    ov_d      = ov_q;
    comp_d    = comp_q;
    val_d     = val_q;
    if (cmd_i.load) begin
      if (req_type_i == REQ_DC) begin
        pos_d     = '0;
        zeros_d   = '0;
        has_val_d = 1'b1;
        ov_d      = 1'b0;
        comp_d    = comp_cl;
        val_d     = pred_new;
      end else if (block_open) begin
        zeros_d   = ac_zeros;
        has_val_d = ac_has_val;
        ov_d      = ac_ov;
        val_d     = mag_value({1'b0, symbol_i[3:0]}, extra_bits_i);
      end
    end else if (cmd_i.step) begin
      pos_d = (pos_inc == BS) ? '0 : pos_inc;
      if (emit_zero) zeros_d = zeros_q - PW'(1);
      else has_val_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      zeros_q   <= '0;
      has_val_q <= 1'b0;
      ov_q      <= 1'b0;
      comp_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      zeros_q   <= zeros_d;
      has_val_q <= has_val_d;
      ov_q      <= ov_d;
      comp_q    <= comp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // Clear predictors on a new scan, then update the DC component
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) pred_q[i] <= '0;
    end else if (cmd_i.load) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        if (req_type_i == REQ_DC && comp_cl[CW-1:0] == CW'(i)) begin
          pred_q[i] <= pred_new;
        end else if (new_scan_i) begin
          pred_q[i] <= '0;
        end
      end
    end
  end

  // Capture one coefficient per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_pos_q  <= POS_W'(pos_q);
      out_coef_q <= emit_zero ? '0 : val_q;
      out_comp_q <= comp_q;
      out_last_q <= (pos_q == LAST_POS);
      out_ov_q   <= ov_q;
    end
  end

  assign position_o    = out_pos_q;
  assign coefficient_o = out_coef_q;
  assign comp_out_o    = out_comp_q;
  assign last_o        = out_last_q;
  assign overrun_o     = out_ov_q;

`ifndef SYNTHESIS
  // A step always has a zero or a value pending
  a_step_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (zeros_q != '0) || has_val_q)
    else $error("step with nothing pending");

  // A DC item restarts the block at position zero without overrun
  a_dc_restarts_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && (req_type_i == REQ_DC) |=> (pos_q == '0) && !ov_q && has_val_q)
    else $error("DC item did not restart the block");
`endif

endmodule

`default_nettype wire

/* rtl/jpeg_baseline_coeff_expand.sv */
// Order: an item is taken only while idle; it is latched, the controller enters
//   its emit state, and each step writes one coefficient into the output register.
// Throughput: one coefficient per cycle while the receiver takes them; no new item is
//   taken until the last step of an item (0 to BLOCK_SIZE - 1 results per item).
// Reset: asynchronous, active low; clears the block position, the DC predictors
//   and the output valid flag.
`default_nettype none

module jpeg_baseline_coeff_expand #(
  parameter int BLOCK_SIZE     = 64,
  parameter int NUM_COMPONENTS = 3
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jbce_in_if.sink    in_i,
  jbce_out_if.source out_o
);
  import jbce_pkg::*;

  jbce_cmd_t cmd;
  jbce_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  jbce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  jbce_dpath #(
    .BLOCK_SIZE     (BLOCK_SIZE),
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (in_i.req_type),
    .symbol_i      (in_i.symbol),
    .extra_bits_i  (in_i.extra_bits),
    .component_i   (in_i.component),
    .new_scan_i    (in_i.new_scan),
    .position_o    (out_o.position),
    .coefficient_o (out_o.coefficient),
    .comp_out_o    (out_o.comp_out),
    .last_o        (out_o.last),
    .overrun_o     (out_o.overrun)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

/* tb/jpeg_baseline_coeff_expand_test.sv */
`default_nettype none

module jpeg_baseline_coeff_expand_test;
  import jbce_pkg::*;

  localparam int BLOCK_SIZE     = 64;
  localparam int NUM_COMPONENTS = 3;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int PHASE_ITEMS    = 115;

  typedef struct packed {
    logic               req_type;
    logic [SYM_W-1:0]   symbol;
    logic [EXTRA_W-1:0] extra_bits;
    logic [COMP_W-1:0]  component;
    logic               new_scan;
  } symbol_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [COEF_W-1:0] coefficient;
    logic [COMP_W-1:0] comp;
    logic              last;
    logic              overrun;
  } coef_t;

  typedef struct packed {
    logic [6:0]               next_pos;
    logic [3:0][COEF_W-1:0]   dc_pred;
    logic [COMP_W-1:0]        blk_comp;
  } expander_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jbce_in_if  in_if ();
  jbce_out_if out_if ();

  jpeg_baseline_coeff_expand #(
    .BLOCK_SIZE    (BLOCK_SIZE),
    .NUM_COMPONENTS(NUM_COMPONENTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  symbol_item_t    symbols_pending[$];
  coef_t           coef_expected[$];
  expander_state_t track_st;   // state seen by accepted items
  expander_state_t plan_st;    // state seen by the stimulus planner
  int              live_items;
  int              items_queued;
  int              items_taken;
  int              errors;
  int              idle_cycles;
  int              src_idle_pct;
  int              snk_idle_pct;
  int              hold_requests;
  int              holds_served;
  int              hold_left;
  bit              in_taken;
  symbol_item_t    taken_sym;
  coef_t           got_coef;
  coef_t           want_coef;

  always #4 clk_i = ~clk_i;

  // Signed magnitude category decode, wrapped to the coefficient width
  function automatic logic [COEF_W-1:0] magnitude(int size, logic [EXTRA_W-1:0] bits);
    logic [EXTRA_W:0] full;
    if (size == 0) return '0;
    if (size > EXTRA_W) size = EXTRA_W;
    full = (17'd1 << size) - 17'd1;
    bits = bits & full[EXTRA_W-1:0];
    if (bits[size-1]) return bits;
    return bits - full[EXTRA_W-1:0];
  endfunction

  function automatic void note_coef(bit record, int pos, logic [COEF_W-1:0] val,
                                    logic [COMP_W-1:0] comp, logic ov);
    coef_t c;
    c.position    = pos[POS_W-1:0];
    c.coefficient = val;
    c.comp        = comp;
    c.last        = (pos == BLOCK_SIZE - 1);
    c.overrun     = ov;
    if (record) coef_expected.push_back(c);
  endfunction

  // Advance the expander state by one symbol; return the coefficient count
  function automatic int expand_item(inout expander_state_t st, input symbol_item_t it,
                                     input bit record);
    int   c;
    int   pos;
    int   remaining;
    int   zeros;
    int   n;
    bit   has_val;
    logic [COEF_W-1:0] val;
    logic ov;
    n       = 0;
    has_val = 1'b0;
    val     = '0;
    if (it.new_scan) st.dc_pred = '0;
    if (it.req_type == REQ_DC) begin
      c = (int'(it.component) >= NUM_COMPONENTS) ? NUM_COMPONENTS - 1 : int'(it.component);
      st.dc_pred[c] = st.dc_pred[c] + magnitude(int'(it.symbol), it.extra_bits);
      st.blk_comp   = c[COMP_W-1:0];
      note_coef(record, 0, st.dc_pred[c], st.blk_comp, 1'b0);
      st.next_pos = 7'd1;
      return 1;
    end
    if (st.next_pos == 0 || st.next_pos >= BLOCK_SIZE) return 0;
    pos       = int'(st.next_pos);
    remaining = BLOCK_SIZE - pos;
    if (it.symbol == SYM_EOB) begin
      zeros = remaining;
    end else if (it.symbol == SYM_ZRL) begin
      zeros = ZRL_RUN;
    end else begin
      zeros   = int'(it.symbol[7:4]);
      has_val = 1'b1;
      val     = magnitude(int'(it.symbol[3:0]), it.extra_bits);
    end
    ov = (zeros + has_val > remaining);
    for (int i = 0; i < zeros && pos < BLOCK_SIZE; i++) begin
      note_coef(record, pos, '0, st.blk_comp, ov);
      pos++;
      n++;
    end
    if (has_val && pos < BLOCK_SIZE) begin
      note_coef(record, pos, val, st.blk_comp, ov);
      pos++;
      n++;
    end
    st.next_pos = (pos >= BLOCK_SIZE) ? 7'd0 : pos[6:0];
    return n;
  endfunction

  task automatic add_item(logic req, logic [SYM_W-1:0] sym, logic [EXTRA_W-1:0] extra,
                          logic [COMP_W-1:0] comp, logic ns);
    symbol_item_t it;
    it = {req, sym, extra, comp, ns};
    if (expand_item(plan_st, it, 1'b0) > 0) live_items++;
    symbols_pending.push_back(it);
    items_queued++;
  endtask

  // One well-formed block with random content, now and then noise or an abandoned block
  task automatic add_block();
    int pick;
    int run;
    int size;
    logic [SYM_W-1:0] sym;
    if (plan_st.next_pos == 0 && $urandom_range(99) < 5)
      add_item(REQ_AC, SYM_W'($urandom_range(0, 255)), EXTRA_W'($urandom_range(0, 65535)),
               COMP_W'($urandom_range(0, 3)), $urandom_range(99) < 20);
    add_item(REQ_DC,
             SYM_W'(($urandom_range(99) < 5) ? $urandom_range(12, 255)
                                             : $urandom_range(0, 11)),
             EXTRA_W'($urandom_range(0, 65535)),
             COMP_W'(($urandom_range(99) < 8) ? 3 : $urandom_range(0, 2)),
             $urandom_range(99) < 5);
    while (plan_st.next_pos != 0) begin
      pick = $urandom_range(99);
      if (pick < 4) break;
      if (pick < 18) begin
        sym = SYM_EOB;
      end else if (pick < 26) begin
        sym = SYM_ZRL;
      end else begin
        run  = $urandom_range(0, 15);
        size = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 15);
        sym  = {run[3:0], size[3:0]};
      end
      add_item(REQ_AC, sym, EXTRA_W'($urandom_range(0, 65535)),
               COMP_W'($urandom_range(0, 3)), $urandom_range(99) < 2);
    end
  endtask

  // Driver: offer the next pending item once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (symbols_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        {in_if.req_type, in_if.symbol, in_if.extra_bits, in_if.component, in_if.new_scan}
          <= symbols_pending.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Monitor: predict on accepted items, check results, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        taken_sym = {in_if.req_type, in_if.symbol, in_if.extra_bits, in_if.component,
                     in_if.new_scan};
        void'(expand_item(track_st, taken_sym, 1'b1));
        items_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        got_coef = {out_if.position, out_if.coefficient, out_if.comp_out, out_if.last,
                    out_if.overrun};
        if (coef_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected coefficient pos=%0d coef=%h comp=%0d last=%b ovr=%b",
                   $time, got_coef.position, got_coef.coefficient, got_coef.comp,
                   got_coef.last, got_coef.overrun);
        end else begin
          want_coef = coef_expected.pop_front();
          if (got_coef !== want_coef) begin
            errors++;
            $display("%0t: mismatch expected pos=%0d coef=%h comp=%0d last=%b ovr=%b",
                     $time, want_coef.position, want_coef.coefficient, want_coef.comp,
                     want_coef.last, want_coef.overrun);
            $display("%0t:          actual   pos=%0d coef=%h comp=%0d last=%b ovr=%b",
                     $time, got_coef.position, got_coef.coefficient, got_coef.comp,
                     got_coef.last, got_coef.overrun);
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
          $display("jpeg_baseline_coeff_expand_test: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.req_type    = REQ_DC;
    in_if.symbol      = '0;
    in_if.extra_bits  = '0;
    in_if.component   = '0;
    in_if.new_scan    = 1'b0;
    out_if.ready      = 1'b0;
    track_st          = '0;
    plan_st           = '0;
    live_items        = 0;
    items_queued      = 0;
    items_taken       = 0;
    errors            = 0;
    idle_cycles       = 0;
    hold_requests     = 0;
    holds_served      = 0;
    hold_left         = 0;
    src_idle_pct      = 21;
    snk_idle_pct      = 62;

    // AC with no open block, then a zero-size DC closed by EOB
    add_item(REQ_AC, 8'h11, 16'hFFFF, 2'd0, 1'b0);
    add_item(REQ_DC, 8'd0, 16'hFFFF, 2'd0, 1'b0);
    add_item(REQ_AC, SYM_EOB, 16'h0000, 2'd0, 1'b0);
    add_item(REQ_AC, 8'h05, 16'h001F, 2'd1, 1'b0);
    // Full-width DC values, saturated size, out-of-range component
    add_item(REQ_DC, 8'd16, 16'h0000, 2'd1, 1'b0);
    add_item(REQ_DC, 8'hFF, 16'hFFFF, 2'd3, 1'b0);
    add_item(REQ_AC, SYM_ZRL, 16'hFFFF, 2'd0, 1'b0);
    add_item(REQ_AC, 8'h30, 16'hFFFF, 2'd1, 1'b0);
    add_item(REQ_AC, 8'h1F, 16'h8000, 2'd2, 1'b0);
    add_item(REQ_AC, 8'hFF, 16'h0000, 2'd3, 1'b0);
    add_item(REQ_AC, SYM_ZRL, 16'h0000, 2'd0, 1'b0);
    // Run past the block end: truncated with overrun
    add_item(REQ_AC, 8'hF5, 16'h0011, 2'd0, 1'b0);
    // Abandoned block, then a new scan
    add_item(REQ_DC, 8'd1, 16'h0001, 2'd2, 1'b0);
    add_item(REQ_AC, 8'h0B, 16'h05A5, 2'd0, 1'b0);
    add_item(REQ_DC, 8'd11, 16'h07FF, 2'd0, 1'b1);
    add_item(REQ_AC, SYM_EOB, 16'hFFFF, 2'd0, 1'b0);
    // ZRL crossing the block end
    add_item(REQ_DC, 8'd5, 16'h0000, 2'd1, 1'b0);
    add_item(REQ_AC, SYM_ZRL, 16'h1234, 2'd1, 1'b0);
    add_item(REQ_AC, SYM_ZRL, 16'h1234, 2'd1, 1'b0);
    add_item(REQ_AC, SYM_ZRL, 16'h1234, 2'd1, 1'b0);
    add_item(REQ_AC, SYM_ZRL, 16'h1234, 2'd1, 1'b0);
    // Predictor clear on an ignored AC item
    add_item(REQ_AC, 8'h22, 16'hAAAA, 2'd2, 1'b1);
    add_item(REQ_DC, 8'd2, 16'h0002, 2'd1, 1'b0);
    add_item(REQ_AC, 8'h01, 16'h0000, 2'd0, 1'b0);
    add_item(REQ_AC, SYM_EOB, 16'h5555, 2'd0, 1'b0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Three idle profiles, a long receiver hold-off in the last one
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 62 : 0;
      snk_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 21 : 0;
      begin
        int target;
        target = live_items + PHASE_ITEMS;
        while (live_items < target) add_block();
      end
      if (ph == 2) hold_requests++;
      while (items_taken != items_queued || coef_expected.size() != 0) @(negedge clk_i);
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("jpeg_baseline_coeff_expand_test: PASS");
    end else begin
      $display("jpeg_baseline_coeff_expand_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/jbce_pkg.sv
rtl/jbce_in_if.sv
rtl/jbce_out_if.sv
rtl/jbce_ctrl.sv
rtl/jbce_dpath.sv
rtl/jpeg_baseline_coeff_expand.sv
tb/jpeg_baseline_coeff_expand_test.sv
